// ===== design/tkahn_pkg.sv =====
// Package for the topological sort block: sizes, widths and field widths.
// Used by the top level and the checker; depends on nothing.
`default_nettype none
package tkahn_pkg;
	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES    = 256;
	localparam int VA_W  = $clog2(MAX_VERTICES);   // vertex address
	localparam int VC_W  = VA_W + 1;               // vertex count
	localparam int EA_W  = $clog2(MAX_EDGES);      // edge address
	localparam int EC_W  = EA_W + 1;               // edge count
	localparam int DEG_W = EC_W;                   // in-degree
	localparam int CFG_W = 6;                      // vertex_count register
	localparam int VTX_W = 5;                      // vertex fields
endpackage
`default_nettype wire

// ===== design/tkahn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none
module tkahn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port, data held when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/topological_sort_kahn.sv =====
// Kahn topological sort with a LIFO ready stack: control sequencer and its memories.
// Depends on tkahn_pkg and tkahn_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries requests: cmd 0 loads one edge
//   from_vertex -> to_vertex, cmd 1 runs the sort. Output channel
//   (out_valid / out_stall) returns one request per emitted vertex, then a
//   status request with last set, has_cycle and edges_dropped. cfg_wr_en and
//   cfg_wr_data write vertex_count (reset value 32); user: idle only, unchecked.
// Sequence:
//   An edge load reads the in-degree, then writes it back incremented.
//   A sort first seeds the stack with every vertex of in-degree zero, then for
//   each popped vertex scans every stored edge, decrementing the in-degree of
//   each target of an edge that leaves that vertex: the edge scan sets the pace.
// Reset:
//   arst_n clears control state and in-degree valid bits; the edge and stack
//   memories need no clearing. The store is cleared after every sort.
// Stall:
//   A result waits in the output register while out_stall is high; the
//   sequencer holds until the register is free. in_stall is high while busy.
`default_nettype none
module topological_sort_kahn
	import tkahn_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             cmd,
	input  wire logic [VTX_W-1:0] from_vertex,
	input  wire logic [VTX_W-1:0] to_vertex,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [VTX_W-1:0] vertex,
	output logic                  is_vertex,
	output logic                  has_cycle,
	output logic                  edges_dropped,
	output logic                  last
);
	typedef enum logic [3:0] {
		S_IDLE, S_INC, S_INIT, S_POP, S_POP_WAIT, S_EMIT, S_E_CHK, S_D_UPD, S_STATUS
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    vcount_q;
	logic [EC_W-1:0]     edge_cnt_q;
	logic [EC_W-1:0]     e_q;
	logic [VC_W-1:0]     cnt_q;
	logic [VC_W-1:0]     sp_q;
	logic [VC_W-1:0]     emitted_q;
	logic                dropped_q;
	logic [MAX_VERTICES-1:0] vld_q;
	logic                rd_vld_q;
	logic                rd_s1;
	logic [VA_W-1:0]     v_s1;
	logic [VA_W-1:0]     v_q;
	logic [VA_W-1:0]     t_q;
	logic                out_valid_q;
	logic [VTX_W-1:0]    vertex_q;
	logic                is_vertex_q, has_cycle_q, dropped_out_q, last_q;

	// memory ports
	logic                ed_we, ed_re;
	logic [EA_W-1:0]     ed_raddr;
	logic [2*VA_W-1:0]   ed_rdata;
	logic                id_we, id_re;
	logic [VA_W-1:0]     id_waddr, id_raddr;
	logic [DEG_W-1:0]    id_wdata, id_rdata;
	logic                st_we, st_re;
	logic [VA_W-1:0]     st_wdata, st_raddr;
	logic [VA_W-1:0]     st_rdata;

	logic [VC_W-1:0]     n_eff;
	logic                acc, edge_ok, out_free, edge_next, match;
	logic [DEG_W-1:0]    deg;
	logic [VA_W-1:0]     e_src, e_tgt;

	// saturate the vertex count
	assign n_eff = (VC_W'(vcount_q) > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES)
		: VC_W'(vcount_q);
	assign acc       = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign edge_ok   = (VC_W'(from_vertex) < n_eff) && (VC_W'(to_vertex) < n_eff)
		&& (edge_cnt_q < EC_W'(MAX_EDGES));
	assign out_free  = !out_valid_q || !out_stall;
	assign edge_next = (e_q < edge_cnt_q);
	assign e_src     = ed_rdata[2*VA_W-1:VA_W];
	assign e_tgt     = ed_rdata[VA_W-1:0];
	assign match     = (e_src == v_q) && (VC_W'(e_tgt) < n_eff) && (VC_W'(e_src) < n_eff);
	assign deg       = rd_vld_q ? id_rdata : '0;

	// memory control from state
	always_comb begin
		ed_we    = acc && !cmd && edge_ok;
		ed_re    = 1'b0;
		ed_raddr = e_q[EA_W-1:0];
		id_re    = 1'b0;
		id_raddr = to_vertex[VA_W-1:0];
		id_we    = 1'b0;
		id_waddr = t_q;
		id_wdata = deg + DEG_W'(1);
		st_we    = 1'b0;
		st_wdata = t_q;
		st_re    = 1'b0;
		st_raddr = VA_W'(sp_q - VC_W'(1));
		unique case (state_q)
			S_IDLE: begin
				id_re = acc && !cmd && edge_ok;
			end
			S_INC: begin
				id_we = 1'b1;
			end
			S_INIT: begin
				id_re    = (cnt_q < n_eff);
				id_raddr = cnt_q[VA_W-1:0];
				st_we    = rd_s1 && (deg == '0);
				st_wdata = v_s1;
			end
			S_POP: begin
				st_re = (sp_q != '0);
			end
			S_EMIT: begin
				ed_re    = out_free && (edge_cnt_q != '0);
				ed_raddr = '0;
			end
			S_E_CHK: begin
				id_re    = match;
				id_raddr = e_tgt;
				ed_re    = !match && edge_next;
			end
			S_D_UPD: begin
				id_we    = (deg != '0);
				id_wdata = deg - DEG_W'(1);
				st_we    = (deg == DEG_W'(1));
				ed_re    = edge_next;
			end
			S_POP_WAIT, S_STATUS: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= CFG_W'(32);
			edge_cnt_q  <= '0;
			e_q         <= '0;
			cnt_q       <= '0;
			sp_q        <= '0;
			emitted_q   <= '0;
			dropped_q   <= 1'b0;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			// drop an accepted result unless a new one is loaded this cycle
			if (out_valid_q && !out_stall && (state_q != S_EMIT)
				&& (state_q != S_STATUS)) begin
				out_valid_q <= 1'b0;
			end
			if (id_re) begin
				rd_vld_q <= vld_q[id_raddr];
			end
			if (id_we) begin
				vld_q[id_waddr] <= 1'b1;
			end
			if (st_we) begin
				sp_q <= sp_q + VC_W'(1);
			end
			if (ed_re) begin
				e_q <= (state_q == S_EMIT) ? EC_W'(1) : e_q + EC_W'(1);
			end
			rd_s1 <= (state_q == S_INIT) && id_re;
			v_s1  <= cnt_q[VA_W-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (acc && cmd) begin
						sp_q      <= '0;
						emitted_q <= '0;
						cnt_q     <= '0;
						state_q   <= S_INIT;
					end else if (acc && edge_ok) begin
						edge_cnt_q <= edge_cnt_q + EC_W'(1);
						t_q        <= to_vertex[VA_W-1:0];
						state_q    <= S_INC;
					end else if (acc) begin
						dropped_q <= 1'b1;
					end
				end
				S_INC: begin
					state_q <= S_IDLE;
				end
				S_INIT: begin
					if (id_re) begin
						cnt_q <= cnt_q + VC_W'(1);
					end else if (!rd_s1) begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_STATUS;
					end else begin
						sp_q    <= sp_q - VC_W'(1);
						state_q <= S_POP_WAIT;
					end
				end
				S_POP_WAIT: begin
					v_q     <= st_rdata;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						vertex_q      <= VTX_W'(v_q);
						is_vertex_q   <= 1'b1;
						has_cycle_q   <= 1'b0;
						dropped_out_q <= 1'b0;
						last_q        <= 1'b0;
						emitted_q     <= emitted_q + VC_W'(1);
						state_q       <= (edge_cnt_q != '0) ? S_E_CHK : S_POP;
					end
				end
				S_E_CHK: begin
					if (match) begin
						t_q     <= e_tgt;
						state_q <= S_D_UPD;
					end else if (!edge_next) begin
						state_q <= S_POP;
					end
				end
				S_D_UPD: begin
					state_q <= edge_next ? S_E_CHK : S_POP;
				end
				S_STATUS: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						vertex_q      <= '0;
						is_vertex_q   <= 1'b0;
						has_cycle_q   <= (emitted_q < n_eff);
						dropped_out_q <= dropped_q;
						last_q        <= 1'b1;
						vld_q         <= '0;
						edge_cnt_q    <= '0;
						dropped_q     <= 1'b0;
						sp_q          <= '0;
						emitted_q     <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex        = vertex_q;
	assign is_vertex     = is_vertex_q;
	assign has_cycle     = has_cycle_q;
	assign edges_dropped = dropped_out_q;
	assign last          = last_q;

	// edge store: source and target side by side
	tkahn_ram #(.WIDTH(2*VA_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (ed_we),
		.waddr (edge_cnt_q[EA_W-1:0]),
		.wdata ({from_vertex[VA_W-1:0], to_vertex[VA_W-1:0]}),
		.re    (ed_re),
		.raddr (ed_raddr),
		.rdata (ed_rdata)
	);

	// in-degree per vertex, masked by valid bits
	tkahn_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (id_waddr),
		.wdata (id_wdata),
		.re    (id_re),
		.raddr (id_raddr),
		.rdata (id_rdata)
	);

	// ready stack
	tkahn_ram #(.WIDTH(VA_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (sp_q[VA_W-1:0]),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);
endmodule
`default_nettype wire

// ===== design/tkahn_checker.sv =====
// Port-level checker for the topological sort block, bound to the top level.
// Depends on tkahn_pkg.
`default_nettype none
module tkahn_checker
	import tkahn_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             cmd,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [VTX_W-1:0] vertex,
	input wire logic             is_vertex,
	input wire logic             has_cycle,
	input wire logic             edges_dropped,
	input wire logic             last
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex) && $stable(last))
		else $error("stalled result changed");

	// status request carries no vertex
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !is_vertex && vertex == '0)
		else $error("status request malformed");

	// vertex requests carry no status flags
	a_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_vertex |-> !last && !has_cycle && !edges_dropped)
		else $error("vertex request carries status");

	// a sort keeps the input stalled next cycle
	a_sort_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd |=> in_stall)
		else $error("input taken during sort");
endmodule

bind topological_sort_kahn tkahn_checker u_tkahn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.cmd           (cmd),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.vertex        (vertex),
	.is_vertex     (is_vertex),
	.has_cycle     (has_cycle),
	.edges_dropped (edges_dropped),
	.last          (last)
);
`default_nettype wire
